// ----- rtl/lscb_pkg.sv -----
// shared types and constants for the laser scan corridor brake
package lscb_pkg;

	// default sizing
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int TABLE_DEPTH_DEF = 512;

	// angle units are 1/64 degree
	localparam int ANGLE_W = 14;
	localparam int ADDR_W = 13;
	localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 14'd5760;
	localparam logic [ANGLE_W-1:0] ANGLE_HALF = 14'd11520;

	// configuration port
	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROBOT_WIDTH = 2'd0,
		REG_RANGE_THRESHOLD = 2'd1,
		REG_ANGLE_STEP = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] ROBOT_WIDTH_RST = 16'd500;
	localparam logic [15:0] RANGE_THRESHOLD_RST = 16'd1000;
	localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST = 14'd64;

	// table entries are unsigned q1.15, 0..32768
	typedef logic [15:0] frac_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// one scan sample
	typedef struct packed {
		logic [15:0] range_mm;
		logic last_sample;
	} sample_t;

	// one converted point plus verdict
	typedef struct packed {
		logic signed [16:0] x_mm;
		logic [15:0] y_mm;
		logic scan_done;
		logic stop;
		logic [9:0] stop_index;
	} result_t;

	// read side of the sine rom
	typedef struct packed {
		logic en;
		addr_t sin_addr;
		addr_t cos_addr;
	} rom_rd_t;

endpackage

// ----- rtl/lscb_sine_rom.sv -----
// constant sine table addressed by angle in 1/64 degree, two registered read ports
module lscb_sine_rom import lscb_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic    clk,
	input  rom_rd_t rd,
	output frac_t   sin_val,
	output frac_t   cos_val
);

	localparam int ROM_DEPTH = int'(ANGLE_QUARTER) + 1;
	localparam int QUARTER_INT = int'(ANGLE_QUARTER);
	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

	// ceil(2^42 / ((2n)(2n+1))): exact floor division for numerators below 2^32
	localparam int RECIP_SH = 42;
	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SH;
	localparam logic [47:0] TAYLOR_RECIP [12] = '{
		48'((RECIP_ONE + 64'd5) / 64'd6),
		48'((RECIP_ONE + 64'd19) / 64'd20),
		48'((RECIP_ONE + 64'd41) / 64'd42),
		48'((RECIP_ONE + 64'd71) / 64'd72),
		48'((RECIP_ONE + 64'd109) / 64'd110),
		48'((RECIP_ONE + 64'd155) / 64'd156),
		48'((RECIP_ONE + 64'd209) / 64'd210),
		48'((RECIP_ONE + 64'd271) / 64'd272),
		48'((RECIP_ONE + 64'd341) / 64'd342),
		48'((RECIP_ONE + 64'd419) / 64'd420),
		48'((RECIP_ONE + 64'd505) / 64'd506),
		48'((RECIP_ONE + 64'd599) / 64'd600)
	};

	// sin(x) for x in q30 radians by integer taylor series, rounded to q15
	function automatic frac_t sine_entry(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		logic [95:0] prod;
		term = x;
		sum = x;
		for (int n = 1; n <= 12; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			prod = 96'(term) * 96'(TAYLOR_RECIP[n-1]);
			term = 64'(prod >> RECIP_SH);
			if (n % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		q = (sum + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[15:0];
	endfunction

	frac_t rom [ROM_DEPTH];

	// contents fixed at elaboration: nearest table entry for each angle in 0..90 deg
	for (genvar a = 0; a < ROM_DEPTH; a++) begin : g_rom
		localparam int IDX_RAW = (a * TABLE_DEPTH + QUARTER_INT / 2) / QUARTER_INT;
		localparam int IDX = (IDX_RAW > TABLE_DEPTH) ? TABLE_DEPTH : IDX_RAW;
		localparam logic [63:0] X = 64'(IDX) * PIHALF_Q30 / 64'(TABLE_DEPTH);
		localparam frac_t ENTRY = sine_entry(X);
		assign rom[a] = ENTRY;
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (rd.en) begin
			sin_val <= rom[rd.sin_addr];
			cos_val <= rom[rd.cos_addr];
		end
	end

endmodule

// ----- rtl/laser_scan_corridor_brake.sv -----
// top level: polar to cartesian conversion of laser samples and corridor stop verdict
//
//   channel   dir  handshake                     payload
//   sample    in   sample_valid / sample_ready   sample_t (range_mm, last_sample)
//   result    out  result_valid / result_ready   result_t (x_mm, y_mm, verdict)
//   config    in   wr_en                         wr_index, wr_data
//
// one sample per cycle while sample_ready is high; a taken beat passes three registered
// stages (sine rom read with sample register, multiply, verdict/output register)
// reset clears the scan counters, the obstacle latch and all stage valids,
// and loads the register defaults
// a stalled result holds the output register; earlier stages keep filling, and
// sample_ready drops only when all three stages hold beats

module laser_scan_corridor_brake import lscb_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

	// configuration registers
	logic [15:0] width_q;
	logic [15:0] thr_q;
	logic [ANGLE_W-1:0] step_q;

	// scan state
	logic [IDX_W-1:0] cnt_q;
	logic [ANGLE_W-1:0] acc_q;
	logic hit_q;
	logic [IDX_W-1:0] pos_q;

	// stage valids and advance
	logic v_s1, v_s2, result_valid_q;
	logic adv1, adv2, adv_out;
	logic take;

	// stage payloads
	logic [15:0] range_s1, range_s2;
	logic last_s1, last_s2;
	logic neg_s1, neg_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [15:0] xmag_s2, ymag_s2;
	frac_t sin_s1, cos_s1;
	result_t result_q;

	// front-end angle logic
	logic neg;
	logic [ANGLE_W-1:0] angle_m;
	rom_rd_t rom_rd;
	logic [ANGLE_W:0] acc_sum;
	logic [ANGLE_W-1:0] acc_next;

	// products
	logic [31:0] xprod, yprod;

	// verdict
	logic cand;
	logic hit_now;
	logic [IDX_W-1:0] pos_now;
	logic [16:0] x_signed;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ROBOT_WIDTH_RST;
			thr_q <= RANGE_THRESHOLD_RST;
			step_q <= ANGLE_STEP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROBOT_WIDTH:     width_q <= wr_data;
				REG_RANGE_THRESHOLD: thr_q <= wr_data;
				REG_ANGLE_STEP:      step_q <= wr_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance chain
	assign adv_out = !result_valid_q || result_ready;
	assign adv2 = !v_s2 || adv_out;
	assign adv1 = !v_s1 || adv2;
	assign sample_ready = adv1;
	assign take = sample_valid && sample_ready;

	// mirror angles past 90 deg, cosine read at the complement; next angle saturates at 180 deg
	always_comb begin
		neg = acc_q > ANGLE_QUARTER;
		angle_m = neg ? ANGLE_HALF - acc_q : acc_q;
		rom_rd.en = adv1;
		rom_rd.sin_addr = angle_m[ADDR_W-1:0];
		rom_rd.cos_addr = ANGLE_QUARTER[ADDR_W-1:0] - angle_m[ADDR_W-1:0];
		acc_sum = {1'b0, acc_q} + {1'b0, step_q};
		acc_next = (acc_sum > {1'b0, ANGLE_HALF}) ? ANGLE_HALF : acc_sum[ANGLE_W-1:0];
	end

	// sample index (saturating) and angle advance per accepted beat; last sample clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
		end else if (take) begin
			if (sample.last_sample) begin
				cnt_q <= '0;
				acc_q <= '0;
			end else begin
				if (cnt_q < IDX_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
				acc_q <= acc_next;
			end
		end
	end

	lscb_sine_rom #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_rom (
		.clk     (clk),
		.rd      (rom_rd),
		.sin_val (sin_s1),
		.cos_val (cos_s1)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= sample_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				result_valid_q <= v_s2;
			end
		end
	end

	// stage 1: sample alongside the rom read
	always_ff @(posedge clk) begin
		if (adv1) begin
			range_s1 <= sample.range_mm;
			last_s1 <= sample.last_sample;
			neg_s1 <= neg;
			idx_s1 <= cnt_q;
		end
	end

	// stage 2: rounded products r*cos and r*sin
	assign xprod = 32'(range_s1) * 32'(cos_s1) + 32'd16384;
	assign yprod = 32'(range_s1) * 32'(sin_s1) + 32'd16384;

	always_ff @(posedge clk) begin
		if (adv2) begin
			xmag_s2 <= xprod[30:15];
			ymag_s2 <= yprod[30:15];
			range_s2 <= range_s1;
			last_s2 <= last_s1;
			neg_s2 <= neg_s1;
			idx_s2 <= idx_s1;
		end
	end

	// corridor test and first-hit latch
	always_comb begin
		cand = !hit_q && ({1'b0, xmag_s2, 1'b0} <= {2'b00, width_q}) && (range_s2 <= thr_q);
		hit_now = hit_q || cand;
		pos_now = cand ? idx_s2 : pos_q;
		x_signed = neg_s2 ? 17'd0 - {1'b0, xmag_s2} : {1'b0, xmag_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			pos_q <= '0;
		end else if (adv_out && v_s2) begin
			if (last_s2) begin
				hit_q <= 1'b0;
				pos_q <= '0;
			end else begin
				hit_q <= hit_now;
				pos_q <= pos_now;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			result_q.x_mm <= signed'(x_signed);
			result_q.y_mm <= ymag_s2;
			result_q.scan_done <= last_s2;
			result_q.stop <= last_s2 && hit_now;
			result_q.stop_index <= (last_s2 && hit_now) ? 10'(pos_now) : 10'd0;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
